>>> design/ehcc_pkg.sv
// Shared types and constants for the extension header chain checker.
`default_nettype none

package ehcc_pkg;

  localparam logic       CMD_BEGIN      = 1'b0;
  localparam logic       CMD_BYTE       = 1'b1;
  localparam logic       STATUS_VALID   = 1'b0;
  localparam logic       STATUS_INVALID = 1'b1;
  localparam logic [2:0] LEN_CODE_NONE  = 3'd0;
  localparam logic [2:0] LEN_CODE_MAX   = 3'd5;
  localparam logic [15:0] MIN_PROTOCOL_TYPE_RESET = 16'd1536;

  typedef struct packed {
    logic        cmd;
    logic [15:0] first_type;
    logic [11:0] area_length;
    logic [7:0]  data_byte;
  } in_item_t;

  typedef struct packed {
    logic        status;
    logic [15:0] proto_type;
    logic [11:0] consumed_length;
  } out_item_t;

  typedef struct packed {
    logic        walking;
    logic [15:0] cur_type;
    logic [12:0] chain_offset;
    logic [11:0] byte_position;
    logic [11:0] area_limit;
    logic [7:0]  held_high_byte;
  } chain_state_t;

  typedef struct packed {
    chain_state_t state;
    logic         emit;
    out_item_t    result;
  } step_out_t;

endpackage

`default_nettype wire

>>> design/ehcc_step.sv
// Combinational chain step: next walk state and result for one request.
`default_nettype none

module ehcc_step import ehcc_pkg::*; #(
  parameter int MAX_AREA_BYTES = 4095
) (
  input  wire in_item_t     item,
  input  wire chain_state_t state,
  input  wire logic [15:0]  min_type,
  output step_out_t         step
);

  localparam logic [16:0] MaxArea = 17'(MAX_AREA_BYTES);

  typedef struct packed {
    logic        walk;
    logic [12:0] offset;
    logic        emit;
    out_item_t   result;
  } adv_t;

  // Examine a type word at the current offset.
  function automatic adv_t advance(input logic [15:0] ct, input logic [12:0] off,
                                   input logic [11:0] lim, input logic [15:0] min_t);
    adv_t        a;
    logic [2:0]  code;
    logic [12:0] off2;
    logic        done;
    logic        bad;
    code = ct[10:8];
    off2 = off + {9'd0, code, 1'b0};
    done = 1'b0;
    bad  = 1'b0;
    if (off >= {1'b0, lim} || ct[15:11] != 5'd0) begin
      done = 1'b1;
    end else if (code == LEN_CODE_NONE || code > LEN_CODE_MAX) begin
      done = 1'b1;
      bad  = 1'b1;
    end else if (off2 > {1'b0, lim}) begin
      done = 1'b1;
      bad  = 1'b1;
    end
    if (ct < min_t) begin
      bad = 1'b1;
    end
    a.walk   = !done;
    a.offset = off2;
    a.emit   = done;
    if (bad) begin
      a.result = '{status: STATUS_INVALID, proto_type: 16'd0, consumed_length: 12'd0};
    end else begin
      a.result = '{status: STATUS_VALID, proto_type: ct, consumed_length: off2[11:0]};
    end
    // A clean end leaves the offset where it stood.
    if (done && !bad) begin
      a.result.consumed_length = off[11:0];
    end
    return a;
  endfunction

  logic [11:0] lim_sat;
  logic [13:0] pos_ext;
  logic [13:0] off_ext;
  logic [15:0] joined_type;
  adv_t        adv_begin;
  adv_t        adv_byte;

  always_comb begin
    if ({5'd0, item.area_length} > MaxArea) begin
      lim_sat = MaxArea[11:0];
    end else begin
      lim_sat = item.area_length;
    end
    pos_ext     = {2'd0, state.byte_position};
    off_ext     = {1'b0, state.chain_offset};
    joined_type = {state.held_high_byte, item.data_byte};
    adv_begin   = advance(item.first_type, 13'd0, lim_sat, min_type);
    adv_byte    = advance(joined_type, state.chain_offset, state.area_limit, min_type);

    step.state  = state;
    step.emit   = 1'b0;
    step.result = adv_byte.result;

    if (item.cmd == CMD_BEGIN) begin
      step.state.cur_type       = item.first_type;
      step.state.area_limit     = lim_sat;
      step.state.byte_position  = 12'd0;
      step.state.held_high_byte = 8'd0;
      step.state.walking        = adv_begin.walk;
      step.state.chain_offset   = adv_begin.walk ? adv_begin.offset : 13'd0;
      step.emit                 = adv_begin.emit;
      step.result               = adv_begin.result;
    end else if (state.walking) begin
      step.state.byte_position = state.byte_position + 12'd1;
      if (pos_ext + 14'd2 == off_ext) begin
        step.state.held_high_byte = item.data_byte;
      end else if (pos_ext + 14'd1 == off_ext) begin
        step.state.cur_type = joined_type;
        step.state.walking  = adv_byte.walk;
        if (adv_byte.walk) begin
          step.state.chain_offset = adv_byte.offset;
        end
        step.emit = adv_byte.emit;
      end
    end
  end

endmodule

`default_nettype wire

>>> design/ehcc_outbuf.sv
// Two-entry result buffer that decouples the result side from the step stage.
`default_nettype none

module ehcc_outbuf import ehcc_pkg::*; (
  input  wire             clk,
  input  wire             rst,
  input  wire             push,
  input  wire out_item_t  push_item,
  output logic            has_space,
  output logic            out_valid,
  input  wire             out_ready,
  output out_item_t       out_data
);

  logic [1:0] count;
  out_item_t  head;
  out_item_t  tail;
  logic       pop;

  assign pop       = out_valid && out_ready;
  assign out_valid = count != 2'd0;
  assign has_space = count != 2'd2;
  assign out_data  = head;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else begin
      case (count)
        2'd0: begin
          if (push) begin
            count <= 2'd1;
          end
        end
        2'd1: begin
          if (push && !pop) begin
            count <= 2'd2;
          end else if (!push && pop) begin
            count <= 2'd0;
          end
        end
        2'd2: begin
          if (pop) begin
            count <= 2'd1;
          end
        end
        default: begin
          count <= 2'd0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (count)
      2'd0: begin
        if (push) begin
          head <= push_item;
        end
      end
      2'd1: begin
        if (push && pop) begin
          head <= push_item;
        end else if (push) begin
          tail <= push_item;
        end
      end
      2'd2: begin
        if (pop) begin
          head <= tail;
        end
      end
      default: begin
        head <= push_item;
      end
    endcase
  end

endmodule

`default_nettype wire

>>> design/extension_header_chain_checker_top.sv
// Top level of the extension header chain checker: request stage, chain state, results.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+---------------------------------------
//   in      | input     | in_valid / in_ready  | in_data: cmd, first_type, area_length,
//           |           |                      |          data_byte
//   out     | output    | out_valid / out_ready| out_data: status, proto_type,
//           |           |                      |           consumed_length
//   cfg     | input     | cfg_valid / cfg_ready| cfg_data: minimum protocol type
//
// One request per cycle while the result buffer has space: an accepted request is
// held in the request register and decided there by the chain step logic once the
// buffer has space. A request that ends a walk pushes its result into the buffer,
// which drives out. The chain state registers take one step per decided request. A
// stalled result side fills a two-entry buffer; in_ready drops only while that buffer
// is full and a request is held. Synchronous reset clears the walk and the
// buffer and loads the minimum protocol type with 1536. cfg_ready is always high.
`default_nettype none

module extension_header_chain_checker_top import ehcc_pkg::*; #(
  parameter int MAX_AREA_BYTES = 4095
) (
  input  wire             clk,
  input  wire             rst,
  input  wire             in_valid,
  output logic            in_ready,
  input  wire in_item_t   in_data,
  output logic            out_valid,
  input  wire             out_ready,
  output out_item_t       out_data,
  input  wire             cfg_valid,
  output logic            cfg_ready,
  input  wire [15:0]      cfg_data
);

  logic         stage_valid;
  in_item_t     stage_item;
  chain_state_t chain;
  logic [15:0]  min_type;
  step_out_t    step;
  logic         buf_space;
  logic         fire;

  // Decide the held request only when its result has somewhere to go.
  assign fire      = stage_valid && buf_space;
  assign in_ready  = !stage_valid || buf_space;
  assign cfg_ready = 1'b1;

  // Request register.
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      stage_valid <= 1'b1;
    end else if (fire) begin
      stage_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      stage_item <= in_data;
    end
  end

  // Chain walk state; advance once per decided request.
  always_ff @(posedge clk) begin
    if (rst) begin
      chain <= '0;
    end else if (fire) begin
      chain <= step.state;
    end
  end

  // Minimum protocol type register.
  always_ff @(posedge clk) begin
    if (rst) begin
      min_type <= MIN_PROTOCOL_TYPE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      min_type <= cfg_data;
    end
  end

  ehcc_step #(
    .MAX_AREA_BYTES(MAX_AREA_BYTES)
  ) u_step (
    .item    (stage_item),
    .state   (chain),
    .min_type(min_type),
    .step    (step)
  );

  ehcc_outbuf u_outbuf (
    .clk      (clk),
    .rst      (rst),
    .push     (fire && step.emit),
    .push_item(step.result),
    .has_space(buf_space),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

endmodule

`default_nettype wire
